FILE: rtl/core/mm64_pkg.sv
// ---------------------------------------------------------------------------
// mm64_pkg - shared definitions for the 64-bit key hasher
// Constants of the hash, command and status types between the controller
// and the datapath.
// ---------------------------------------------------------------------------
package mm64_pkg;

   localparam logic [63:0] MIX_MUL       = 64'hc6a4a7935bd1e995;
   localparam int          MIX_SHIFT     = 47;
   localparam logic [63:0] SEED_RESET    = 64'hdeadbeefdeadbeef;
   localparam logic [31:0] MAX_KEY_BYTES = 32'd65535;

   // operand fed to the shared multiplier
   typedef enum logic [1:0] {
      SEL_LEN,
      SEL_WORD,
      SEL_K,
      SEL_H
   } mul_sel_type;

   // partial product taken in one multiply step
   typedef enum logic [1:0] {
      PH_LL,   // low operand half times low constant half
      PH_LH,   // low operand half times high constant half
      PH_HL    // high operand half times low constant half
   } mul_phase_type;

   // register update done in a write-back step
   typedef enum logic [2:0] {
      WB_NONE,
      WB_SEED,     // h = seed ^ product
      WB_KMIX,     // k = product ^ (product >> 47)
      WB_HXOR,     // h ^= product
      WB_TAIL,     // h ^= masked tail word
      WB_HSET,     // h = product, k = avalanche prep of product
      WB_AVPREP,   // k = h ^ (h >> 47)
      WB_OUT       // result = product ^ (product >> 47)
   } wb_op_type;

   typedef struct packed {
      logic          capture;
      logic          mul_en;
      mul_sel_type   mul_sel;
      mul_phase_type mul_phase;
      wb_op_type     wb_op;
   } cmd_type;

   typedef struct packed {
      logic is_first;
      logic is_last;
      logic full;
      logic nonzero;
      logic ends;
   } status_type;

endpackage

FILE: rtl/core/mm64_dpath.sv
// ---------------------------------------------------------------------------
// mm64_dpath - hash datapath
// Input word capture, seed register, running hash, one shared 32x32
// multiplier building 64-bit products over three steps, and result register.
// ---------------------------------------------------------------------------
module mm64_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  mm64_pkg::cmd_type    cmd,
   output mm64_pkg::status_type status,
   input  logic                 csr_valid,
   input  logic [63:0]          csr_seed_value,
   input  logic [63:0]          req_data_word,
   input  logic [3:0]           req_valid_bytes,
   input  logic [15:0]          req_total_length,
   input  logic                 req_is_first,
   input  logic                 req_is_last,
   output logic [63:0]          rsp_hash_value
);
   import mm64_pkg::*;

   logic [63:0] seed_ff;
   logic [63:0] h_ff, h_in;
   logic [63:0] k_ff, k_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] word_ff;
   logic [15:0] len_ff, len_sat;
   logic [2:0]  nbytes_ff;
   logic        first_ff, last_ff, full_ff, nonzero_ff;
   logic [63:0] result_ff, result_in;
   logic [63:0] mul_a;
   logic [31:0] mul_x, mul_y;
   logic [63:0] mul_p;
   logic [63:0] mixed;
   logic [63:0] h_mixed;
   logic [63:0] tail_mask;

   // saturate the key length used for seeding
   assign len_sat = ({16'b0, req_total_length} > MAX_KEY_BYTES) ?
                    MAX_KEY_BYTES[15:0] : req_total_length;

   // select multiplier operand and the halves for this step
   always_comb begin
      unique case (cmd.mul_sel)
         SEL_LEN:  mul_a = {48'b0, len_ff};
         SEL_WORD: mul_a = word_ff;
         SEL_K:    mul_a = k_ff;
         SEL_H:    mul_a = h_ff;
         default:  mul_a = h_ff;
      endcase
      mul_x = (cmd.mul_phase == PH_HL) ? mul_a[63:32] : mul_a[31:0];
      mul_y = (cmd.mul_phase == PH_LH) ? MIX_MUL[63:32] : MIX_MUL[31:0];
      mul_p = mul_x * mul_y;
   end

   // accumulate the low 64 bits of the product
   always_comb begin
      prod_in = prod_ff;
      if (cmd.mul_en) begin
         if (cmd.mul_phase == PH_LL) begin
            prod_in = mul_p;
         end else begin
            prod_in = {prod_ff[63:32] + mul_p[31:0], prod_ff[31:0]};
         end
      end
   end

   assign mixed     = prod_ff ^ (prod_ff >> MIX_SHIFT);
   assign h_mixed   = h_ff ^ (h_ff >> MIX_SHIFT);
   assign tail_mask = (64'h1 << {nbytes_ff, 3'b000}) - 64'h1;

   // write back into hash, key and result registers
   always_comb begin
      h_in      = h_ff;
      k_in      = k_ff;
      result_in = result_ff;
      unique case (cmd.wb_op)
         WB_NONE:   ;
         WB_SEED:   h_in = seed_ff ^ prod_ff;
         WB_KMIX:   k_in = mixed;
         WB_HXOR:   h_in = h_ff ^ prod_ff;
         WB_TAIL:   h_in = h_ff ^ (word_ff & tail_mask);
         WB_HSET: begin
            h_in = prod_ff;
            k_in = mixed;
         end
         WB_AVPREP: k_in = h_mixed;
         WB_OUT:    result_in = mixed;
         default:   ;
      endcase
   end

   // hold seed and running hash
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
         h_ff    <= 64'b0;
      end else begin
         if (csr_valid) begin
            seed_ff <= csr_seed_value;
         end
         h_ff <= h_in;
      end
   end

   // capture the input word and advance the working registers
   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      prod_ff   <= prod_in;
      result_ff <= result_in;
      if (cmd.capture) begin
         word_ff    <= req_data_word;
         len_ff     <= len_sat;
         nbytes_ff  <= req_valid_bytes[2:0];
         first_ff   <= req_is_first;
         last_ff    <= req_is_last;
         full_ff    <= (req_valid_bytes >= 4'd8);
         nonzero_ff <= (req_valid_bytes != 4'd0);
      end
   end

   assign status.is_first = first_ff;
   assign status.is_last  = last_ff;
   assign status.full     = full_ff;
   assign status.nonzero  = nonzero_ff;
   assign status.ends     = last_ff | (nonzero_ff & ~full_ff);

   assign rsp_hash_value = result_ff;

endmodule

FILE: rtl/core/mm64_ctrl.sv
// ---------------------------------------------------------------------------
// mm64_ctrl - hash sequencer
// Walks each word through the seeding, key mixing, hash mixing and final
// avalanche it needs, steps the shared multiplier and owns the result valid.
// ---------------------------------------------------------------------------
module mm64_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mm64_pkg::status_type status,
   output mm64_pkg::cmd_type    cmd
);
   import mm64_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SEED_MUL,
      ST_SEED_WB,
      ST_K1_MUL,
      ST_K1_WB,
      ST_K2_MUL,
      ST_K2_WB,
      ST_TAIL,
      ST_H_MUL,
      ST_H_WB,
      ST_AV_PREP,
      ST_AV_MUL,
      ST_AV_WB
   } state_type;

   state_type     state_ff, state_in;
   mul_phase_type phase_ff, phase_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;
   logic          in_mul;
   logic          mul_last;
   state_type     data_route;

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign in_mul    = (state_ff == ST_SEED_MUL) || (state_ff == ST_K1_MUL) ||
                      (state_ff == ST_K2_MUL) || (state_ff == ST_H_MUL) ||
                      (state_ff == ST_AV_MUL);
   assign mul_last  = (phase_ff == PH_HL);

   // pick the data path for a word once it is seeded
   always_comb begin
      priority if (status.full) begin
         data_route = ST_K1_MUL;
      end else if (status.nonzero) begin
         data_route = ST_TAIL;
      end else if (status.is_last) begin
         data_route = ST_AV_PREP;
      end else begin
         data_route = ST_IDLE;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_DECODE;
         ST_DECODE:   state_in = status.is_first ? ST_SEED_MUL : data_route;
         ST_SEED_MUL: if (mul_last) state_in = ST_SEED_WB;
         ST_SEED_WB:  state_in = data_route;
         ST_K1_MUL:   if (mul_last) state_in = ST_K1_WB;
         ST_K1_WB:    state_in = ST_K2_MUL;
         ST_K2_MUL:   if (mul_last) state_in = ST_K2_WB;
         ST_K2_WB:    state_in = ST_H_MUL;
         ST_TAIL:     state_in = ST_H_MUL;
         ST_H_MUL:    if (mul_last) state_in = ST_H_WB;
         ST_H_WB:     state_in = status.ends ? ST_AV_MUL : ST_IDLE;
         ST_AV_PREP:  state_in = ST_AV_MUL;
         ST_AV_MUL:   if (mul_last) state_in = ST_AV_WB;
         ST_AV_WB:    if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // step the multiplier phase inside multiply states
   always_comb begin
      phase_in = phase_ff;
      if (in_mul) begin
         unique case (phase_ff)
            PH_LL:   phase_in = PH_LH;
            PH_LH:   phase_in = PH_HL;
            PH_HL:   phase_in = PH_LL;
            default: phase_in = PH_LL;
         endcase
      end
   end

   // set result valid on write, drop it when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_AV_WB) && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_LL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // decode commands for the datapath
   always_comb begin
      cmd.capture   = (state_ff == ST_IDLE) && req_valid;
      cmd.mul_en    = in_mul;
      cmd.mul_phase = phase_ff;
      unique case (state_ff)
         ST_SEED_MUL: cmd.mul_sel = SEL_LEN;
         ST_K1_MUL:   cmd.mul_sel = SEL_WORD;
         ST_K2_MUL:   cmd.mul_sel = SEL_K;
         ST_AV_MUL:   cmd.mul_sel = SEL_K;
         default:     cmd.mul_sel = SEL_H;
      endcase
      unique case (state_ff)
         ST_SEED_WB: cmd.wb_op = WB_SEED;
         ST_K1_WB:   cmd.wb_op = WB_KMIX;
         ST_K2_WB:   cmd.wb_op = WB_HXOR;
         ST_TAIL:    cmd.wb_op = WB_TAIL;
         ST_H_WB:    cmd.wb_op = WB_HSET;
         ST_AV_PREP: cmd.wb_op = WB_AVPREP;
         ST_AV_WB:   cmd.wb_op = out_free ? WB_OUT : WB_NONE;
         default:    cmd.wb_op = WB_NONE;
      endcase
   end

endmodule

FILE: rtl/core/murmur64a_key_hasher_core.sv
// ---------------------------------------------------------------------------
// murmur64a_key_hasher_core - 64-bit MurmurHash64A key hasher
// Takes a key as little-endian 64-bit words and gives its 64-bit hash.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one word per handshake, with its valid byte count, the key
//            length (used on the first word) and first/last marks. A word
//            with one to seven valid bytes ends the key. An empty key is one
//            word with zero valid bytes marked first and last.
//   rsp_*  : one hash word per key, held in an output register.
//   csr_*  : seed write, always ready; write only while the block is idle.
// Sequence: each 64-bit product is built on one 32x32 multiplier from
//   partial products and then written back. A word is accepted and
//   decoded, seeded when first, then key mixed and hash mixed when full
//   or tail folded and hash mixed when partial, and goes through the
//   avalanche when the key ends (with a prep step if no data was mixed).
// Reset: seed returns to 0xdeadbeefdeadbeef, running hash to zero, no
//   result pending. A stalled receiver only holds the block at the result
//   write; the next word is taken while a result waits.
// ---------------------------------------------------------------------------
module murmur64a_key_hasher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic [15:0] req_total_length,
   input  logic        req_is_first,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_hash_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_seed_value
);
   import mm64_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   mm64_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mm64_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid),
      .csr_seed_value   (csr_seed_value),
      .req_data_word    (req_data_word),
      .req_valid_bytes  (req_valid_bytes),
      .req_total_length (req_total_length),
      .req_is_first     (req_is_first),
      .req_is_last      (req_is_last),
      .rsp_hash_value   (rsp_hash_value)
   );

endmodule

FILE: rtl/core/mm64_checker.sv
// ---------------------------------------------------------------------------
// mm64_checker - port-level checks for the key hasher
// Watches the top-level handshakes and attaches to the core by bind.
// ---------------------------------------------------------------------------
module mm64_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_hash_value
);

   // hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_value))
      else $error("result word changed or dropped while stalled");

   // drop ready for the cycle after a word is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after an accepted word");

   // a new result only appears out of a busy sequence
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result raised while the block was idle");

endmodule

bind murmur64a_key_hasher_core mm64_checker u_mm64_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hash_value (rsp_hash_value)
);

FILE: tb/sv/murmur64a_key_hasher_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// murmur64a_key_hasher_core_tb - self-checking bench for the key hasher
// Walks a short table of hand-picked words, including zero and all-ones
// data, many byte counts and the unmarked partial tail. It then streams
// random keys, broken keys and noise words under several seeds. Each
// accepted word is run through a local model of the hash. Each hash word
// that comes out is compared with the oldest predicted one. The sender
// idles in bursts and the receiver stalls on a pattern of its own.
// ---------------------------------------------------------------------------
module murmur64a_key_hasher_core_tb;
   import mm64_pkg::*;

   localparam int QUIET_LIMIT = 4000;   // cycles with no handshake on any port
   localparam int IDLE_CYCLES = 40;     // covers the slowest word
   localparam int PHASE_WORDS = 150;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_LIGHT,
      RX_HEAVY,
      RX_BURSTY
   } rx_mode_type;

   typedef struct packed {
      bit          seed_wr;   // write seed before this row, block idle
      logic [63:0] seed;
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic [15:0] length;
      logic        first;
      logic        last;
      bit          typed;     // hash typed in below instead of predicted
      logic [63:0] hash;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_data_word;
   logic [3:0]  req_valid_bytes;
   logic [15:0] req_total_length;
   logic        req_is_first;
   logic        req_is_last;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_hash_value;
   logic        csr_valid;
   logic        csr_ready;
   logic [63:0] csr_seed_value;

   // typed hash that travels with the word on the request side
   bit          row_typed;
   logic [63:0] row_hash;

   logic [63:0] model_seed = SEED_RESET;
   logic [63:0] model_hash = '0;
   logic [63:0] pending_digests[$];
   int          errors = 0;
   int          words_sent = 0;
   int          burst_left = 0;
   int          quiet_cycles = 0;

   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 0;
   logic [4:0]  rx_tick = '0;

   dir_row_type dir_rows [0:21] = '{
      // after reset, no data and no first word: hash stays zero
      '{1'b0, 64'd0, 64'h0123_4567_89ab_cdef, 4'd0, 16'd0, 1'b0, 1'b1, 1'b1, 64'd0},
      '{1'b0, 64'd0, 64'd0, 4'd0, 16'd0, 1'b1, 1'b1, 1'b0, 64'd0},
      '{1'b0, 64'd0, 64'hffff_ffff_ffff_ffff, 4'd8, 16'd8, 1'b1, 1'b1, 1'b0, 64'd0},
      '{1'b0, 64'd0, 64'd0, 4'd8, 16'd8, 1'b1, 1'b1, 1'b0, 64'd0},
      // one-byte tail ends the key without a last mark
      '{1'b0, 64'd0, 64'hffff_ffff_ffff_ffff, 4'd1, 16'd1, 1'b1, 1'b0, 1'b0, 64'd0},
      '{1'b0, 64'd0, 64'hffff_ffff_ffff_ffff, 4'd7, 16'd7, 1'b1, 1'b1, 1'b0, 64'd0},
      // byte count above eight, longest length
      '{1'b0, 64'd0, 64'hffff_ffff_ffff_ffff, 4'd15, 16'hffff, 1'b1, 1'b1, 1'b0, 64'd0},
      '{1'b0, 64'd0, 64'h8000_0000_0000_0001, 4'd9, 16'd16, 1'b1, 1'b0, 1'b0, 64'd0},
      '{1'b0, 64'd0, 64'hfedc_ba98_7654_3210, 4'd8, 16'd16, 1'b0, 1'b1, 1'b0, 64'd0},
      // empty word that only loads the seed
      '{1'b0, 64'd0, 64'hffff_ffff_ffff_ffff, 4'd0, 16'd12, 1'b1, 1'b0, 1'b0, 64'd0},
      '{1'b0, 64'd0, 64'h5555_5555_5555_5555, 4'd8, 16'd0, 1'b0, 1'b1, 1'b0, 64'd0},
      // no first word: continue from the kept pre-avalanche hash
      '{1'b0, 64'd0, 64'haaaa_aaaa_aaaa_aaaa, 4'd8, 16'd0, 1'b0, 1'b1, 1'b0, 64'd0},
      '{1'b0, 64'd0, 64'hffff_ffff_ffff_ffff, 4'd8, 16'd11, 1'b1, 1'b0, 1'b0, 64'd0},
      '{1'b0, 64'd0, 64'h1122_3344_5566_7788, 4'd3, 16'd0, 1'b0, 1'b0, 1'b0, 64'd0},
      // length that does not match the words sent
      '{1'b0, 64'd0, 64'hffff_ffff_ffff_ffff, 4'd8, 16'd3, 1'b1, 1'b1, 1'b0, 64'd0},
      // zero seed with zero data hashes to zero
      '{1'b1, 64'd0, 64'd0, 4'd0, 16'd0, 1'b1, 1'b1, 1'b1, 64'd0},
      '{1'b0, 64'd0, 64'd0, 4'd8, 16'd0, 1'b1, 1'b1, 1'b1, 64'd0},
      // unused high bytes are masked off, so this is still zero
      '{1'b0, 64'd0, 64'hffff_ff00_0000_0000, 4'd5, 16'd0, 1'b1, 1'b0, 1'b1, 64'd0},
      '{1'b1, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 4'd8, 16'hffff,
        1'b1, 1'b1, 1'b0, 64'd0},
      '{1'b0, 64'd0, 64'd0, 4'd0, 16'd0, 1'b0, 1'b0, 1'b0, 64'd0},
      '{1'b0, 64'd0, 64'd0, 4'd0, 16'd0, 1'b0, 1'b1, 1'b0, 64'd0},
      '{1'b0, 64'd0, 64'h0123_4567_89ab_cdef, 4'd4, 16'd4, 1'b1, 1'b1, 1'b0, 64'd0}
   };

   murmur64a_key_hasher_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_word    (req_data_word),
      .req_valid_bytes  (req_valid_bytes),
      .req_total_length (req_total_length),
      .req_is_first     (req_is_first),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hash_value   (rsp_hash_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_seed_value   (csr_seed_value)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // final mix: xor-shift, multiply, xor-shift
   function automatic logic [63:0] finish_hash(input logic [63:0] h);
      logic [63:0] x;
      x = h ^ (h >> MIX_SHIFT);
      x = x * MIX_MUL;
      return x ^ (x >> MIX_SHIFT);
   endfunction

   // fold one word into the model hash; return 1 when the key ends
   function automatic bit absorb_word(input logic [63:0] w, input logic [3:0] nb,
                                      input logic [15:0] len, input logic f,
                                      input logic l, output logic [63:0] digest);
      logic [63:0] h;
      logic [63:0] k;
      logic [63:0] mask;
      logic [31:0] eff_len;
      bit          ends;
      h = model_hash;
      ends = l;
      if (f) begin
         eff_len = (32'(len) > MAX_KEY_BYTES) ? MAX_KEY_BYTES : 32'(len);
         h = model_seed ^ (64'(eff_len) * MIX_MUL);
      end
      if (nb >= 4'd8) begin
         k = w * MIX_MUL;
         k = k ^ (k >> MIX_SHIFT);
         k = k * MIX_MUL;
         h = (h ^ k) * MIX_MUL;
      end else if (nb != 4'd0) begin
         mask = (64'd1 << (32'(nb) * 8)) - 64'd1;
         h = (h ^ (w & mask)) * MIX_MUL;
         ends = 1'b1;
      end
      model_hash = h;
      digest = finish_hash(h);
      return ends;
   endfunction

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   // check hash words, predict from accepted key words, track seed writes
   always @(posedge clock) begin : scoreboard
      logic [63:0] digest;
      logic [63:0] want;
      if (reset) begin
         model_seed = SEED_RESET;
         model_hash = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_digests.size() == 0) begin
               flag_error($sformatf("unexpected hash word %h", rsp_hash_value));
            end else begin
               want = pending_digests.pop_front();
               if (rsp_hash_value !== want)
                  flag_error($sformatf("hash_value expected %h got %h", want, rsp_hash_value));
            end
         end
         if (req_valid && req_ready) begin
            if (absorb_word(req_data_word, req_valid_bytes, req_total_length,
                            req_is_first, req_is_last, digest))
               pending_digests.insert(pending_digests.size(),
                                      row_typed ? row_hash : digest);
         end
         if (csr_valid && csr_ready) model_seed = csr_seed_value;
      end
   end

   // receiver: switch between open, light, heavy and bursty stall modes
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_left <= 0;
      end else begin
         if (rx_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
         end else begin
            rx_left <= rx_left - 1;
         end
         rx_tick <= rx_tick + 5'd1;
         case (rx_mode)
            RX_OPEN:  rsp_ready <= 1'b1;
            RX_LIGHT: rsp_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:  rsp_ready <= (rx_tick >= 5'd24);
         endcase
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("murmur64a_key_hasher_core_tb failed");
            $finish;
         end
      end
   end

   // hold valid low between bursts of random length
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // offer one key word and hold it until accepted
   task automatic send_word(input logic [63:0] w, input logic [3:0] nb,
                            input logic [15:0] len, input logic f, input logic l,
                            input bit typed, input logic [63:0] hash);
      req_valid <= 1'b1;
      req_data_word <= w;
      req_valid_bytes <= nb;
      req_total_length <= len;
      req_is_first <= f;
      req_is_last <= l;
      row_typed <= typed;
      row_hash <= hash;
      do @(posedge clock); while (!(req_valid && req_ready));
      words_sent++;
      pace();
   endtask

   // drop valid and wait for every predicted hash word
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_digests.size() != 0) @(posedge clock);
   endtask

   // drain, then let a word that gives no hash finish inside the block
   task automatic wait_idle();
      wait_drained();
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_seed_value <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   // stream one key, optionally without first mark, wrong length or last mark
   task automatic send_key(input bit no_first, input bit bad_len, input bit no_last);
      int          nbytes;
      int          nwords;
      int          rem;
      int          sz;
      logic [3:0]  nb;
      logic [15:0] len_field;
      sz = $urandom_range(0, 19);
      nbytes = (sz < 14) ? $urandom_range(0, 24) :
               (sz < 19) ? $urandom_range(25, 96) : $urandom_range(97, 400);
      len_field = bad_len ? 16'($urandom) : 16'(nbytes);
      nwords = (nbytes == 0) ? 1 : (nbytes + 7) / 8;
      for (int i = 0; i < nwords; i++) begin
         rem = nbytes - 8 * i;
         nb = (rem >= 8) ? 4'd8 : 4'(rem);
         if (nb == 4'd8 && $urandom_range(0, 9) == 0) nb = 4'($urandom_range(9, 15));
         send_word({$urandom, $urandom}, nb, len_field, (i == 0) && !no_first,
                   (i == nwords - 1) && !no_last, 1'b0, 64'd0);
      end
   endtask

   initial begin : stimulus
      int          target;
      int          pick;
      logic [63:0] seed;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_word = '0;
      req_valid_bytes = '0;
      req_total_length = '0;
      req_is_first = 1'b0;
      req_is_last = 1'b0;
      row_typed = 1'b0;
      row_hash = '0;
      csr_valid = 1'b0;
      csr_seed_value = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      foreach (dir_rows[i]) begin
         if (dir_rows[i].seed_wr) begin
            wait_idle();
            write_seed(dir_rows[i].seed);
         end
         send_word(dir_rows[i].word, dir_rows[i].nbytes, dir_rows[i].length,
                   dir_rows[i].first, dir_rows[i].last, dir_rows[i].typed,
                   dir_rows[i].hash);
      end

      // random keys under reset, zero, all-ones and random seeds
      for (int p = 0; p < 5; p++) begin
         case (p)
            0:       seed = SEED_RESET;
            1:       seed = 64'd0;
            2:       seed = 64'hffff_ffff_ffff_ffff;
            default: seed = {$urandom, $urandom};
         endcase
         wait_idle();
         write_seed(seed);
         target = words_sent + PHASE_WORDS;
         while (words_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
               send_key(1'b0, 1'b0, 1'b0);
            else if (pick < 90)
               send_key(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
            else
               send_word({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                         16'($urandom), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'b0, 64'd0);
            if ($urandom_range(0, 39) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (IDLE_CYCLES) @(posedge clock);
      if (errors == 0 && pending_digests.size() == 0)
         $display("murmur64a_key_hasher_core_tb passed");
      else
         $display("murmur64a_key_hasher_core_tb failed");
      $finish;
   end

endmodule
